// ===== hdl/mrd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrd_pkg
// types, constants and the byte-wide crc-16 step of the response decoder
// ----------------------------------------------------------------------------
package mrd_pkg;

  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'hA001;
  localparam logic [7:0]  SlaveAddrReset = 8'h01;

  localparam logic [2:0] PosAddr   = 3'd0;
  localparam logic [2:0] PosFunc   = 3'd1;
  localparam logic [2:0] PosCount  = 3'd2;
  localparam logic [2:0] PosValHi  = 3'd3;
  localparam logic [2:0] PosValLo  = 3'd4;
  localparam logic [2:0] PosCrcLo  = 3'd5;
  localparam logic [2:0] PosCrcHi  = 3'd6;
  localparam logic [2:0] PosIdle   = 3'd7;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } mrd_item_t;

  typedef struct packed {
    logic [15:0] reading;
    logic        crc_ok;
  } mrd_result_t;

  // reflected crc-16, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/mrd_in_if.sv =====
// ----------------------------------------------------------------------------
// mrd_in_if
// received byte channel with frame start marker
// ----------------------------------------------------------------------------
interface mrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== hdl/mrd_out_if.sv =====
// ----------------------------------------------------------------------------
// mrd_out_if
// decoded reading channel
// ----------------------------------------------------------------------------
interface mrd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] reading;
  logic        crc_ok;

  modport source (output valid, output reading, output crc_ok, input ready);
  modport sink   (input valid, input reading, input crc_ok, output ready);
endinterface

// ===== hdl/mrd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mrd_cfg_if
// slave address write channel
// ----------------------------------------------------------------------------
interface mrd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] slave_address;

  modport source (output valid, output slave_address, input ready);
  modport sink   (input valid, input slave_address, output ready);
endinterface

// ===== hdl/modbus_response_decode_top.sv =====
// ----------------------------------------------------------------------------
// modbus_response_decode_top
// checks 7-byte modbus rtu read responses and returns the value
// ----------------------------------------------------------------------------
// rx_i takes one frame byte per beat with frame_start marking the address
// byte; a start in mid-frame drops the frame under way. the crc-16 over the
// first five bytes is compared with the received crc. after the seventh byte
// one beat leaves on res_o if the frame address equals the slave address:
// the value, or zero on a crc mismatch, with crc_ok. other frames and bytes
// after a complete frame give nothing.
// cfg_i writes the slave address (reset 0x01); it is always ready.
// a byte goes through an input register and one pass of the byte-wide crc
// into the result register; a frame's result leaves from there on res_o.
// one byte per cycle is sustained while res_o does not stall.
// reset clears the frame state; the first byte after reset counts as an
// address byte. when res_o stalls, the held result waits and rx_i still
// takes one more byte into the input register before it stops.
// ----------------------------------------------------------------------------
module modbus_response_decode_top
  import mrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mrd_in_if.sink     rx_i,
  mrd_cfg_if.sink    cfg_i,
  mrd_out_if.source  res_o
);

  logic        s1_valid;
  mrd_item_t   s1_item;
  logic        advance;
  logic        can_load;
  logic        res_fire;
  mrd_result_t res;
  logic [7:0]  slave_addr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrReset;
    end else if (cfg_i.valid) begin
      slave_addr_q <= cfg_i.slave_address;
    end
  end

  assign advance = s1_valid && can_load;

  mrd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_i      (rx_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  mrd_frame u_frame (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (advance),
    .item_i          (s1_item),
    .slave_address_i (slave_addr_q),
    .res_fire_o      (res_fire),
    .res_o           (res)
  );

  mrd_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_fire),
    .res_i      (res),
    .can_load_o (can_load),
    .res_o      (res_o)
  );

endmodule

// ===== hdl/mrd_in_stage.sv =====
// ----------------------------------------------------------------------------
// mrd_in_stage
// input register for received bytes
// ----------------------------------------------------------------------------
module mrd_in_stage
  import mrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  mrd_in_if.sink    rx_i,
  input  logic      advance_i,
  output logic      valid_o,
  output mrd_item_t item_o
);

  logic      valid_q, valid_d;
  mrd_item_t item_q;

  assign rx_i.ready = !valid_q || advance_i;
  assign valid_d    = (rx_i.valid && rx_i.ready) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      item_q <= '{rx_byte: rx_i.rx_byte, frame_start: rx_i.frame_start};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/mrd_frame.sv =====
// ----------------------------------------------------------------------------
// mrd_frame
// frame position tracking, crc accumulation and result decision
// ----------------------------------------------------------------------------
module mrd_frame
  import mrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  mrd_item_t   item_i,
  input  logic [7:0]  slave_address_i,
  output logic        res_fire_o,
  output mrd_result_t res_o
);

  logic [2:0]  pos_q, pos_d, pos;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  addr_q, addr_d;
  logic [15:0] value_q, value_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        ok;

  assign pos = item_i.frame_start ? PosAddr : pos_q;
  assign ok  = ({item_i.rx_byte, crc_lo_q} == crc_q);

  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    addr_d     = addr_q;
    value_d    = value_q;
    crc_lo_d   = crc_lo_q;
    res_fire_o = 1'b0;
    res_o      = '{reading: ok ? value_q : 16'h0000, crc_ok: ok};
    unique case (pos)
      PosAddr: begin
        crc_d  = crc_byte(CrcInit, item_i.rx_byte);
        addr_d = item_i.rx_byte;
        pos_d  = PosFunc;
      end
      PosFunc, PosCount: begin
        crc_d = crc_byte(crc_q, item_i.rx_byte);
        pos_d = pos + 3'd1;
      end
      PosValHi: begin
        crc_d   = crc_byte(crc_q, item_i.rx_byte);
        value_d = {item_i.rx_byte, 8'h00};
        pos_d   = PosValLo;
      end
      PosValLo: begin
        crc_d   = crc_byte(crc_q, item_i.rx_byte);
        value_d = {value_q[15:8], item_i.rx_byte};
        pos_d   = PosCrcLo;
      end
      PosCrcLo: begin
        crc_lo_d = item_i.rx_byte;
        pos_d    = PosCrcHi;
      end
      PosCrcHi: begin
        pos_d      = PosIdle;
        res_fire_o = advance_i && (addr_q == slave_address_i);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosAddr;
      crc_q    <= CrcInit;
      addr_q   <= 8'h00;
      value_q  <= 16'h0000;
      crc_lo_q <= 8'h00;
    end else if (advance_i) begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      addr_q   <= addr_d;
      value_q  <= value_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

// ===== hdl/mrd_out_stage.sv =====
// ----------------------------------------------------------------------------
// mrd_out_stage
// result register toward the reading channel
// ----------------------------------------------------------------------------
module mrd_out_stage
  import mrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  mrd_result_t res_i,
  output logic        can_load_o,
  mrd_out_if.source   res_o
);

  logic        valid_q, valid_d;
  mrd_result_t res_q;

  assign can_load_o = !valid_q || res_o.ready;
  assign valid_d    = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid   = valid_q;
  assign res_o.reading = res_q.reading;
  assign res_o.crc_ok  = res_q.crc_ok;

endmodule

// ===== tb/modbus_response_decode_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_response_decode_top_tb
// self-checking bench for the modbus rtu read response decoder
// ----------------------------------------------------------------------------
// bytes of well-formed, corrupted, foreign, cut-short and noise frames go in
// on rx_i; a scoreboard tracks the frame position and crc-16 of every byte
// taken and checks each reading on res_o. the slave address is rewritten
// between phases while the block is idle. both sides idle at random, the
// reader once holds off for a long stretch.
// ----------------------------------------------------------------------------
module modbus_response_decode_top_tb;
  import mrd_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int LongHoldCycles = 300;
  localparam int PhaseBytes     = 237;
  localparam int NumPhases      = 6;

  class reading_scoreboard;
    logic [7:0]  slave_addr;
    logic [2:0]  pos;
    logic [15:0] crc;
    logic [7:0]  frame_addr;
    logic [15:0] value;
    logic [7:0]  crc_lo;
    mrd_result_t pending[$];
    int          frame_bytes;
    int          ignored_bytes;
    int          frames_done;
    int          readings_checked;
    int          good_crc;
    int          mismatches;

    function new();
      slave_addr       = SlaveAddrReset;
      pos              = PosAddr;
      crc              = CrcInit;
      frame_addr       = 8'h00;
      value            = 16'h0000;
      crc_lo           = 8'h00;
      frame_bytes      = 0;
      ignored_bytes    = 0;
      frames_done      = 0;
      readings_checked = 0;
      good_crc         = 0;
      mismatches       = 0;
    endfunction

    // lsb-first crc-16, one data bit folded in per step
    static function logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ data[i];
        r  = r >> 1;
        if (fb) begin
          r = r ^ CrcPoly;
        end
      end
      return r;
    endfunction

    function void report(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s", msg);
      end
    endfunction

    function void note_byte(input mrd_item_t it);
      logic [2:0]  at;
      logic [15:0] rx_crc;
      mrd_result_t want;
      at = it.frame_start ? PosAddr : pos;
      if (at != PosIdle) begin
        frame_bytes++;
      end
      case (at)
        PosAddr: begin
          crc        = crc16_step(CrcInit, it.rx_byte);
          frame_addr = it.rx_byte;
          pos        = PosFunc;
        end
        PosFunc, PosCount: begin
          crc = crc16_step(crc, it.rx_byte);
          pos = at + 3'd1;
        end
        PosValHi: begin
          crc   = crc16_step(crc, it.rx_byte);
          value = {it.rx_byte, 8'h00};
          pos   = PosValLo;
        end
        PosValLo: begin
          crc        = crc16_step(crc, it.rx_byte);
          value[7:0] = it.rx_byte;
          pos        = PosCrcLo;
        end
        PosCrcLo: begin
          crc_lo = it.rx_byte;
          pos    = PosCrcHi;
        end
        PosCrcHi: begin
          rx_crc = {it.rx_byte, crc_lo};
          pos    = PosIdle;
          frames_done++;
          if (frame_addr == slave_addr) begin
            want.crc_ok  = (rx_crc == crc);
            want.reading = want.crc_ok ? value : 16'h0000;
            pending.push_back(want);
          end
        end
        default: begin
          ignored_bytes++;
        end
      endcase
    endfunction

    function void check_reading(input mrd_result_t got);
      mrd_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("reading %h crc_ok %b with no frame pending", got.reading, got.crc_ok));
        return;
      end
      want = pending.pop_front();
      readings_checked++;
      if (want.crc_ok) begin
        good_crc++;
      end
      if (got.reading !== want.reading) begin
        report($sformatf("reading expected %h got %h", want.reading, got.reading));
      end
      if (got.crc_ok !== want.crc_ok) begin
        report($sformatf("crc_ok expected %b got %b", want.crc_ok, got.crc_ok));
      end
    endfunction

    function void check_drained();
      mrd_result_t want;
      while (pending.size() != 0) begin
        want = pending.pop_front();
        report($sformatf("reading %h crc_ok %b never arrived", want.reading, want.crc_ok));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mrd_in_if  rx_if ();
  mrd_cfg_if cfg_if ();
  mrd_out_if res_if ();

  reading_scoreboard readings;
  bit                gaps_on = 1'b1;
  bit                hold_req = 1'b0;
  int                cycle_count = 0;
  int                addr_settings = 0;

  modbus_response_decode_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count <= CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        return 16'h0000;
      end
      1: begin
        return 16'hFFFF;
      end
      default: begin
        return 16'($urandom);
      end
    endcase
  endfunction

  function automatic logic [6:0][7:0] build_frame(input logic [7:0] a, input logic [15:0] v,
                                                  input bit corrupt);
    logic [6:0][7:0] f;
    logic [15:0]     c;
    f[0] = a;
    f[1] = $urandom_range(0, 1) ? 8'h03 : 8'($urandom);
    f[2] = $urandom_range(0, 1) ? 8'h02 : 8'($urandom);
    f[3] = v[15:8];
    f[4] = v[7:0];
    c = CrcInit;
    for (int k = 0; k < 5; k++) begin
      c = reading_scoreboard::crc16_step(c, f[k]);
    end
    if (corrupt) begin
      c = c ^ (16'h0001 << $urandom_range(0, 15));
    end
    f[5] = c[7:0];
    f[6] = c[15:8];
    return f;
  endfunction

  // reader side: random stalls, one long hold-off on request
  initial begin
    int          stall_left;
    int          held;
    mrd_result_t got;
    stall_left = 0;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got.reading = res_if.reading;
        got.crc_ok  = res_if.crc_ok;
        readings.check_reading(got);
      end
      if (hold_req) begin
        res_if.ready <= 1'b0;
        for (held = 0; held < LongHoldCycles; held++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (stall_left == 0 && gaps_on && $urandom_range(0, 99) < 25) begin
          stall_left = pick_gap();
        end
        if (stall_left > 0) begin
          stall_left--;
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    mrd_item_t it;
    it.rx_byte     = b;
    it.frame_start = s;
    rx_if.valid       <= 1'b1;
    rx_if.rx_byte     <= b;
    rx_if.frame_start <= s;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    readings.note_byte(it);
  endtask

  task automatic byte_gap();
    int g;
    if (!gaps_on) begin
      return;
    end
    g = pick_gap();
    if (g > 0) begin
      rx_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_frame(input logic [6:0][7:0] f, input int n, input logic first_start);
    for (int k = 0; k < n; k++) begin
      send_byte(f[k], (k == 0) ? first_start : 1'b0);
      byte_gap();
    end
  endtask

  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (readings.pending.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_slave_address(input logic [7:0] a);
    cfg_if.valid         <= 1'b1;
    cfg_if.slave_address <= a;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    readings.slave_addr = a;
    addr_settings++;
  endtask

  task automatic run_phase(input int goal, input bit long_hold, input bit mid_drain);
    int          kind;
    int          first;
    bit          drained;
    logic [15:0] v;
    first   = readings.frame_bytes;
    drained = 1'b0;
    if (long_hold) begin
      hold_req = 1'b1;
    end
    while (readings.frame_bytes - first < goal) begin
      if (mid_drain && !drained && readings.frame_bytes - first >= goal / 2) begin
        wait_idle();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      v    = pick_value();
      if (kind < 62) begin
        send_frame(build_frame(readings.slave_addr, v, 1'b0), 7, 1'b1);
      end else if (kind < 74) begin
        send_frame(build_frame(readings.slave_addr, v, 1'b1), 7, 1'b1);
      end else if (kind < 84) begin
        send_frame(build_frame(8'($urandom), v, 1'($urandom_range(0, 1))), 7, 1'b1);
      end else if (kind < 93) begin
        // cut short, the next start drops it
        send_frame(build_frame(readings.slave_addr, v, 1'b0), $urandom_range(1, 6), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom), $urandom_range(0, 3) == 0);
          byte_gap();
        end
      end
    end
  endtask

  initial begin
    logic [7:0] addr_plan [NumPhases];
    rst_ni               <= 1'b0;
    rx_if.valid          <= 1'b0;
    rx_if.rx_byte        <= 8'h00;
    rx_if.frame_start    <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.slave_address <= 8'h00;
    readings = new();
    addr_plan[0] = SlaveAddrReset;
    addr_plan[1] = 8'h00;
    addr_plan[2] = 8'hFF;
    for (int p = 3; p < NumPhases; p++) begin
      addr_plan[p] = 8'($urandom);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first frame after reset comes without a start marker
    send_frame(build_frame(SlaveAddrReset, 16'hFFFF, 1'b0), 7, 1'b0);
    // trailing bytes after a complete frame
    send_byte(8'hFF, 1'b0);
    byte_gap();
    send_byte(8'h00, 1'b0);
    byte_gap();
    send_frame(build_frame(SlaveAddrReset, 16'h0000, 1'b1), 7, 1'b1);
    // restart in mid-frame, then a foreign address
    send_frame(build_frame(SlaveAddrReset, 16'h5A5A, 1'b0), 3, 1'b1);
    send_frame(build_frame(8'hFE, 16'h1234, 1'b0), 7, 1'b1);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        write_slave_address(addr_plan[p]);
      end
      gaps_on = (p != 4);
      run_phase(PhaseBytes, p == 3, p == 2);
      wait_idle();
    end
    repeat (10) @(posedge clk_i);
    readings.check_drained();

    $display("covered %0d frame bytes, %0d complete frames, %0d ignored bytes",
             readings.frame_bytes, readings.frames_done, readings.ignored_bytes);
    $display("%0d readings checked (%0d with good crc) over %0d address writes",
             readings.readings_checked, readings.good_crc, addr_settings);
    if (readings.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", readings.mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
